// File: rtl/rds_pkg.sv
`default_nettype none

package rds_pkg;

	localparam int VALUE_W        = 31;
	localparam int VALUE_BITS_DEF = 31;
	localparam int REQ_W          = 2;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 7;

	typedef enum logic [REQ_W-1:0] {
		MODE_BIN = 2'd0,
		MODE_OCT = 2'd1,
		MODE_HEX = 2'd2,
		MODE_DEC = 2'd3
	} mode_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic shift;
	} rds_cmd_t;

	typedef struct packed {
		logic conv_last;
		logic top_zero;
		logic cnt_one;
	} rds_sts_t;

endpackage

`default_nettype wire

// File: rtl/rds_if.sv
`default_nettype none

interface rds_in_if
	import rds_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [REQ_W-1:0]   req_type;

	modport source (output valid, output value, output req_type, input ready);
	modport sink (input valid, input value, input req_type, output ready);
endinterface

interface rds_out_if
	import rds_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic [CHAR_W-1:0]  digit_char;
	logic               last_digit;

	modport source (output valid, output digit, output digit_char, output last_digit,
		input ready);
	modport sink (input valid, input digit, input digit_char, input last_digit,
		output ready);
endinterface

`default_nettype wire

// File: rtl/rds_ctrl.sv
`default_nettype none

module rds_ctrl
	import rds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [REQ_W-1:0] req_type,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rds_cmd_t              cmd,
	input  wire rds_sts_t         sts
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_TRIM = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (mode_t'(req_type) == MODE_DEC) ? ST_CONV : ST_TRIM;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_last) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				// drop leading zero digits, keep at least one
				if (sts.top_zero && !sts.cnt_one) begin
					cmd.shift = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.cnt_one) begin
						state_d = ST_IDLE;
					end else begin
						cmd.shift = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rds_dp.sv
`default_nettype none

module rds_dp
	import rds_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic [REQ_W-1:0]   req_type,
	input  wire rds_cmd_t           cmd,
	output rds_sts_t                sts,
	output logic [DIGIT_W-1:0]      digit,
	output logic [CHAR_W-1:0]       digit_char,
	output logic                    last_digit
);

	localparam int EFF     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int ND      = (EFF * 30103) / 100000 + 1;
	localparam int SW      = 4 * ND;
	localparam int N_BIN   = EFF;
	localparam int N_OCT   = (EFF + 2) / 3;
	localparam int N_HEX   = (EFF + 3) / 4;
	localparam int SH_BIN  = SW - N_BIN;
	localparam int SH_OCT  = SW - 3 * N_OCT;
	localparam int SH_HEX  = SW - 4 * N_HEX;
	localparam int CW      = $clog2(SW + 1);
	localparam int SCW     = $clog2(EFF + 1);

	logic [SW-1:0]  sr_q;
	logic [SW-1:0]  sr_d;
	logic [SW-1:0]  adj;
	logic [EFF-1:0] bin_q;
	logic [EFF-1:0] val_eff;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_ld;
	logic [SW-1:0]  sr_ld;
	logic [SCW-1:0] stp_q;
	mode_t          mode_q;
	mode_t          mode_in;

	assign val_eff = value[EFF-1:0];
	assign mode_in = mode_t'(req_type);

	// double-dabble nibble correction
	always_comb begin
		for (int j = 0; j < ND; j++) begin
			adj[4*j +: 4] = (sr_q[4*j +: 4] >= 4'd5) ? (sr_q[4*j +: 4] + 4'd3)
				: sr_q[4*j +: 4];
		end
	end

	// left-align the digit grid of the requested radix; decimal mode clears the BCD register
	always_comb begin
		unique case (mode_in)
			MODE_BIN: begin
				sr_ld  = SW'(val_eff) << SH_BIN;
				cnt_ld = CW'(N_BIN);
			end
			MODE_OCT: begin
				sr_ld  = SW'(val_eff) << SH_OCT;
				cnt_ld = CW'(N_OCT);
			end
			MODE_HEX: begin
				sr_ld  = SW'(val_eff) << SH_HEX;
				cnt_ld = CW'(N_HEX);
			end
			MODE_DEC: begin
				sr_ld  = '0;
				cnt_ld = CW'(ND);
			end
		endcase
	end

	always_comb begin
		unique case (mode_q)
			MODE_BIN: begin
				digit = {3'b000, sr_q[SW-1]};
				sr_d  = sr_q << 1;
			end
			MODE_OCT: begin
				digit = {1'b0, sr_q[SW-1 -: 3]};
				sr_d  = sr_q << 3;
			end
			MODE_HEX, MODE_DEC: begin
				digit = sr_q[SW-1 -: 4];
				sr_d  = sr_q << 4;
			end
		endcase
	end

	assign digit_char = (digit < 4'd10) ? (CHAR_W'(digit) + 7'd48) : (CHAR_W'(digit) + 7'd55);
	assign last_digit = sts.cnt_one;

	assign sts.conv_last = (stp_q == SCW'(EFF - 1));
	assign sts.top_zero  = (digit == '0);
	assign sts.cnt_one   = (cnt_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BIN;
			cnt_q  <= '0;
			stp_q  <= '0;
		end else if (cmd.load) begin
			mode_q <= mode_in;
			cnt_q  <= cnt_ld;
			stp_q  <= '0;
		end else if (cmd.conv_step) begin
			stp_q <= stp_q + SCW'(1);
		end else if (cmd.shift) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sr_q  <= sr_ld;
			bin_q <= val_eff;
		end else if (cmd.conv_step) begin
			sr_q  <= {adj[SW-2:0], bin_q[EFF-1]};
			bin_q <= bin_q << 1;
		end else if (cmd.shift) begin
			sr_q <= sr_d;
		end
	end

	a_shift_keeps_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> cnt_q > CW'(1))
		else $error("digit shift with one digit left");

	a_conv_only_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv_step |-> mode_q == MODE_DEC)
		else $error("bcd step outside decimal mode");

	a_conv_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv_step |-> stp_q < SCW'(EFF))
		else $error("bcd step count overrun");

endmodule

`default_nettype wire

// File: rtl/radix_digit_serializer_unit.sv
`default_nettype none

// Converts a non-negative value to binary, octal, hexadecimal or decimal (BCD) digits and
// sends them one transaction per digit, most significant first, leading zeros dropped (zero
// gives a single digit 0); each digit carries its ASCII character and a flag on the last one.
// One value is handled at a time: in.ready is high only while the unit is idle. The digit
// slots of each mode (at 31 bits: 31 binary, 11 octal, 8 hex, 10 decimal) are scanned from
// the top; decimal mode first runs one double-dabble shift-add step per value bit (31).

module radix_digit_serializer_unit
	import rds_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rds_in_if.sink   in_ch,
	rds_out_if.source out_ch
);

	rds_cmd_t cmd;
	rds_sts_t sts;

	rds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.req_type  (in_ch.req_type),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rds_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (in_ch.value),
		.req_type   (in_ch.req_type),
		.cmd        (cmd),
		.sts        (sts),
		.digit      (out_ch.digit),
		.digit_char (out_ch.digit_char),
		.last_digit (out_ch.last_digit)
	);

endmodule

`default_nettype wire

// File: test/radix_digit_serializer_unit_tb.sv
`default_nettype none

module radix_digit_serializer_unit_tb;
	import rds_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 160;
	localparam int MAX_GAP       = 17;
	localparam int PRINT_LIMIT   = 100;

	localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'd55;

	typedef struct {
		logic [VALUE_W-1:0] value;
		mode_t              mode;
		int unsigned        gap;
		bit                 drain;
	} conv_req_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [CHAR_W-1:0]  digit_char;
		logic               last_digit;
	} digit_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rds_in_if  in_ch ();
	rds_out_if out_ch ();

	radix_digit_serializer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	conv_req_t   conv_queue[$];
	digit_rec_t  digits_due[$];
	int          mismatches = 0;
	int          digits_checked = 0;
	int          values_taken = 0;
	int          mode_count[4] = '{0, 0, 0, 0};
	int unsigned rx_wait = 0;
	int unsigned rx_seen = 0;
	int unsigned idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic add_conv(input logic [VALUE_W-1:0] value, input mode_t mode,
		input int unsigned gap, input bit drain);
		conv_req_t r;
		r.value = value;
		r.mode  = mode;
		r.gap   = gap;
		r.drain = drain;
		conv_queue.push_back(r);
	endtask

	// expected digit run for one value, most significant first
	function automatic void predict_digits(input logic [VALUE_W-1:0] value, input mode_t mode);
		logic [VALUE_W-1:0] rest;
		logic [DIGIT_W-1:0] nib_mask;
		logic [DIGIT_W-1:0] found[$];
		int unsigned        step;
		digit_rec_t         rec;
		rest = value;
		if (mode == MODE_DEC) begin
			while (rest != 0) begin
				found.push_front(DIGIT_W'(rest % 10));
				rest = rest / 10;
			end
		end else begin
			step = (mode == MODE_BIN) ? 1 : (mode == MODE_OCT) ? 3 : 4;
			nib_mask = DIGIT_W'((1 << step) - 1);
			while (rest != 0) begin
				found.push_front(DIGIT_W'(rest) & nib_mask);
				rest = rest >> step;
			end
		end
		if (found.size() == 0)
			found.push_back('0);
		foreach (found[i]) begin
			rec.digit      = found[i];
			rec.digit_char = (found[i] < 10) ? ASCII_ZERO + CHAR_W'(found[i])
				: ASCII_LETTER + CHAR_W'(found[i]);
			rec.last_digit = (i == found.size() - 1);
			digits_due.push_back(rec);
		end
	endfunction

	// sender: gap before each value, drain items wait for all digits to return
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid    <= 1'b0;
			in_ch.value    <= '0;
			in_ch.req_type <= MODE_BIN;
		end else if (in_ch.valid && !in_ch.ready) begin
			// transaction still offered
		end else if (conv_queue.size() != 0 && conv_queue[0].gap != 0) begin
			conv_queue[0].gap = conv_queue[0].gap - 1;
			in_ch.valid <= 1'b0;
		end else if (conv_queue.size() != 0 &&
			(!conv_queue[0].drain || (!in_ch.valid && digits_due.size() == 0))) begin
			in_ch.valid    <= 1'b1;
			in_ch.value    <= conv_queue[0].value;
			in_ch.req_type <= conv_queue[0].mode;
			void'(conv_queue.pop_front());
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// receiver: stall per digit, two long hold-offs, calm stretches
	always @(posedge clk or negedge arst_n) begin : rx_side
		int unsigned stall;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_wait      <= 0;
		end else if (out_ch.valid && out_ch.ready) begin
			rx_seen <= rx_seen + 1;
			if (rx_seen == 40 || rx_seen == 300) begin
				rx_wait      <= HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else begin
				stall = ((rx_seen / 80) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
				rx_wait      <= stall;
				out_ch.ready <= (stall == 0);
			end
		end else if (rx_wait != 0) begin
			rx_wait      <= rx_wait - 1;
			out_ch.ready <= (rx_wait == 1);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : digit_check
		digit_rec_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				digits_checked++;
				if (digits_due.size() == 0) begin
					report_mismatch("digit with none pending", out_ch.digit, 0);
				end else begin
					want = digits_due.pop_front();
					if (out_ch.digit !== want.digit)
						report_mismatch("digit", out_ch.digit, want.digit);
					if (out_ch.digit_char !== want.digit_char)
						report_mismatch("digit_char", out_ch.digit_char, want.digit_char);
					if (out_ch.last_digit !== want.last_digit)
						report_mismatch("last_digit", out_ch.last_digit, want.last_digit);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				values_taken++;
				mode_count[in_ch.req_type]++;
				predict_digits(in_ch.value, mode_t'(in_ch.req_type));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [31:0] raw;
		int unsigned width;
		int unsigned gap;
		mode_t       m;

		// zero, full scale and one in every mode
		for (int i = 0; i < 4; i++) begin
			m = mode_t'(i);
			add_conv('0, m, $urandom_range(0, MAX_GAP), 1'b0);
			add_conv({VALUE_W{1'b1}}, m, $urandom_range(0, MAX_GAP), 1'b0);
			add_conv(VALUE_W'(1), m, 0, 1'b0);
		end
		add_conv(VALUE_W'(32'h1ABCDEF0), MODE_HEX, 0, 1'b0);
		add_conv(VALUE_W'(32'h10), MODE_HEX, 3, 1'b0);
		add_conv(VALUE_W'(8), MODE_OCT, 0, 1'b0);
		add_conv(VALUE_W'(7), MODE_OCT, 0, 1'b0);
		add_conv(VALUE_W'(9), MODE_DEC, 5, 1'b0);
		add_conv(VALUE_W'(10), MODE_DEC, 0, 1'b0);
		add_conv(VALUE_W'(1000000000), MODE_DEC, 0, 1'b0);
		add_conv(VALUE_W'(999999999), MODE_DEC, 0, 1'b0);
		add_conv(VALUE_W'(32'h40000000), MODE_BIN, 0, 1'b0);
		add_conv(VALUE_W'(32'h55555555), MODE_BIN, 2, 1'b0);
		add_conv(VALUE_W'(32'h2AAAAAAA), MODE_HEX, 0, 1'b0);

		for (int i = 0; i < 90; i++) begin
			width = ($urandom_range(0, 3) == 0) ? VALUE_W : $urandom_range(0, VALUE_W);
			raw   = $urandom;
			raw   = raw >> (32 - width);
			gap   = ((i / 20) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
			add_conv(raw[VALUE_W-1:0], mode_t'($urandom_range(0, 3)), gap, (i % 25 == 0));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (conv_queue.size() != 0 || in_ch.valid)
			@(negedge clk);
		while (digits_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("converted %0d values: %0d binary, %0d octal, %0d hex, %0d decimal",
			values_taken, mode_count[MODE_BIN], mode_count[MODE_OCT], mode_count[MODE_HEX],
			mode_count[MODE_DEC]);
		$display("checked %0d digit transactions under random stalls and two long hold-offs",
			digits_checked);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
rtl/rds_pkg.sv
rtl/rds_if.sv
rtl/rds_ctrl.sv
rtl/rds_dp.sv
rtl/radix_digit_serializer_unit.sv
test/radix_digit_serializer_unit_tb.sv
